[rtl/swbf_pkg.sv]
// Shared constants, codes and types of the write-coalescing buffer.
`default_nettype none
package swbf_pkg;
  localparam int BLOCK_COUNT  = 128;
  localparam int BUFFER_DEPTH = 8;
  localparam int MAX_ERASE    = 10;

  localparam int LBA_W  = 8;
  localparam int DATA_W = 32;
  localparam int SIZE_W = 4;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;

  // probe address: one bit more than lba so that range ends and the store limit fit
  localparam int PA_W   = LBA_W + 1;
  localparam int ADDR_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int IDX_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ERASE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_ADDR = 2'd1;
  localparam logic [STAT_W-1:0] ST_SIZE = 2'd2;

  typedef struct packed {
    logic [LBA_W-1:0]  lba;
    logic [DATA_W-1:0] data;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } store_cmd_t;
endpackage
`default_nettype wire

[rtl/swbf_if.sv]
// Command and response channel interfaces.
`default_nettype none
interface swbf_cmd_if import swbf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [LBA_W-1:0]  lba;
  logic [DATA_W-1:0] wdata;
  logic [SIZE_W-1:0] erase_count;

  modport source (output valid, action, lba, wdata, erase_count, input ready);
  modport sink (input valid, action, lba, wdata, erase_count, output ready);
endinterface

interface swbf_rsp_if import swbf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] rdata;
  logic [STAT_W-1:0] status;
  logic              flushed;

  modport source (output valid, rdata, status, flushed, input ready);
  modport sink (input valid, rdata, status, flushed, output ready);
endinterface
`default_nettype wire

[rtl/swbf_store.sv]
// Block store: one write and one registered read port, erased state kept in valid bits.
`default_nettype none
module swbf_store import swbf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  store_cmd_t        cmd,
  output logic [DATA_W-1:0] rdata
);
  logic [DATA_W-1:0]      mem [BLOCK_COUNT];
  logic [BLOCK_COUNT-1:0] vld;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    if (cmd.re) begin
      rdata <= vld[cmd.addr] ? mem[cmd.addr] : '0;
    end
  end

  // a block never written reads as erased
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.we) begin
      vld[cmd.addr] <= 1'b1;
    end
  end
endmodule
`default_nettype wire

[rtl/swbf_range.sv]
// Shared range compare: does an entry's range, clamped at the store end, cover the probe.
`default_nettype none
module swbf_range import swbf_pkg::*; (
  input  logic [PA_W-1:0] probe,
  input  entry_t          ent,
  output logic            hit
);
  logic [PA_W-1:0] start;
  logic [PA_W-1:0] stop;

  assign start = {1'b0, ent.lba};
  assign stop  = start + PA_W'(ent.size);
  assign hit   = (probe >= start) && (probe < stop) && (probe < PA_W'(BLOCK_COUNT));
endmodule
`default_nettype wire

[rtl/ssd_write_buffer_with_flush.sv]
// Write-coalescing buffer with flush in front of a block store.
//
// cmd channel: one word per command (write, read, erase, flush), valid/ready.
// rsp channel: one word per command with rdata, status and flushed, valid/ready.
// The block takes one command at a time; cmd.ready is high only when idle.
// Path from cmd accept to rsp valid:
//   write/erase without flush, bad address, bad size: straight to the finish state
//   read: entries from the newest until one covers the lba, else a registered store read
//   flush (explicit or on a full buffer): each entry's blocks written to the store in turn
// All of it runs through one range comparator stepping one entry or one block
// per cycle, and the store's single read/write port.
// The response sits in an output register; if rsp is stalled the next command
// is still taken and worked, and its result waits in the finish state until
// the output register frees up.
// Reset empties the buffer and marks every block erased (reads as zero) at once;
// reset leaves the block in idle, so cmd.ready is high as soon as rst drops.
`default_nettype none
module ssd_write_buffer_with_flush import swbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  swbf_cmd_if.sink   cmd,
  swbf_rsp_if.source rsp
);
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_LOOKUP   = 3'd1;
  localparam logic [2:0] S_STORE_RD = 3'd2;
  localparam logic [2:0] S_STORE_WT = 3'd3;
  localparam logic [2:0] S_FL_ENTRY = 3'd4;
  localparam logic [2:0] S_FL_WALK  = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]        state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [PA_W-1:0]   probe;
  entry_t            pend [BUFFER_DEPTH];
  logic [DATA_W-1:0] res_rdata;
  logic [STAT_W-1:0] res_status;
  logic              res_flushed;
  logic              rsp_valid;
  logic [DATA_W-1:0] rsp_rdata;
  logic [STAT_W-1:0] rsp_status;
  logic              rsp_flushed;

  entry_t            ent;
  logic              hit;
  store_cmd_t        scmd;
  logic [DATA_W-1:0] store_rdata;

  assign ent = pend[idx[IDX_W-1:0]];

  swbf_range u_range (
    .probe (probe),
    .ent   (ent),
    .hit   (hit)
  );

  always_comb begin
    scmd.we    = (state == S_FL_WALK) && hit;
    scmd.re    = (state == S_STORE_RD);
    scmd.addr  = probe[ADDR_W-1:0];
    scmd.wdata = ent.data;
  end

  swbf_store u_store (
    .clk   (clk),
    .rst   (rst),
    .cmd   (scmd),
    .rdata (store_rdata)
  );

  assign cmd.ready   = (state == S_IDLE);
  assign rsp.valid   = rsp_valid;
  assign rsp.rdata   = rsp_rdata;
  assign rsp.status  = rsp_status;
  assign rsp.flushed = rsp_flushed;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // the finish state reloads the output register itself
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            res_rdata   <= '0;
            res_status  <= ST_OK;
            res_flushed <= 1'b0;
            probe       <= {1'b0, cmd.lba};
            priority if (cmd.action == ACT_FLUSH) begin
              idx         <= '0;
              res_flushed <= 1'b1;
              state       <= S_FL_ENTRY;
            end else if ({1'b0, cmd.lba} >= PA_W'(BLOCK_COUNT)) begin
              res_status <= ST_ADDR;
              state      <= S_DONE;
            end else if (cmd.action == ACT_READ) begin
              if (count == '0) begin
                state <= S_STORE_RD;
              end else begin
                idx   <= count - 1'b1;
                state <= S_LOOKUP;
              end
            end else if (cmd.action == ACT_ERASE &&
                         cmd.erase_count > SIZE_W'(MAX_ERASE)) begin
              res_status <= ST_SIZE;
              state      <= S_DONE;
            end else begin
              pend[count[IDX_W-1:0]].lba  <= cmd.lba;
              pend[count[IDX_W-1:0]].data <= (cmd.action == ACT_WRITE) ? cmd.wdata : '0;
              pend[count[IDX_W-1:0]].size <= (cmd.action == ACT_WRITE) ?
                                             SIZE_W'(1) : cmd.erase_count;
              count <= count + 1'b1;
              // the entry that fills the buffer drains it in the same command
              if (count == CNT_W'(BUFFER_DEPTH - 1)) begin
                idx         <= '0;
                res_flushed <= 1'b1;
                state       <= S_FL_ENTRY;
              end else begin
                state <= S_DONE;
              end
            end
          end
        end
        S_LOOKUP: begin
          // newest to oldest, first cover wins
          if (hit) begin
            res_rdata <= ent.data;
            state     <= S_DONE;
          end else if (idx == '0) begin
            state <= S_STORE_RD;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_STORE_RD: begin
          state <= S_STORE_WT;
        end
        S_STORE_WT: begin
          res_rdata <= store_rdata;
          state     <= S_DONE;
        end
        S_FL_ENTRY: begin
          if (idx == count) begin
            count <= '0;
            state <= S_DONE;
          end else begin
            probe <= {1'b0, ent.lba};
            state <= S_FL_WALK;
          end
        end
        S_FL_WALK: begin
          // one block per cycle; range end and store end stop the walk
          if (hit) begin
            probe <= probe + 1'b1;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_FL_ENTRY;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid   <= 1'b1;
            rsp_rdata   <= res_rdata;
            rsp_status  <= res_status;
            rsp_flushed <= res_flushed;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/swbf_chk.sv]
// Port-level checker for the write-coalescing buffer, bound to the top level.
`default_nettype none
module swbf_chk import swbf_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [DATA_W-1:0] rsp_rdata,
  input logic [STAT_W-1:0] rsp_status,
  input logic              rsp_flushed
);
  // one command at a time: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("cmd ready right after accept");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rdata) &&
                                $stable(rsp_status) && $stable(rsp_flushed))
    else $error("stalled rsp word changed");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_rdata == '0 && !rsp_flushed)
    else $error("error rsp carries data or flush");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_ADDR || rsp_status == ST_SIZE)
    else $error("bad status code");

  a_flush_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_flushed |-> rsp_status == ST_OK && rsp_rdata == '0)
    else $error("flush rsp not clean");
endmodule

bind ssd_write_buffer_with_flush swbf_chk u_swbf_chk (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_rdata   (rsp.rdata),
  .rsp_status  (rsp.status),
  .rsp_flushed (rsp.flushed)
);
`default_nettype wire
